FILE: sv/ptrr_pkg.sv
// Package for the process table block: field widths, operation, action and
// status codes, sequencer states and the request and response payload types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptrr_pkg;

   // Default table size
   localparam int DEPTH_DEFAULT = 1024;

   // Field widths
   localparam int MODE_W     = 2;
   localparam int REF_W      = 32;
   localparam int PID_W      = 32;
   localparam int ACTION_W   = 3;
   localparam int STATUS_W   = 3;
   localparam int AFFECTED_W = 10;
   localparam int LIVE_W     = 11;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_SPAWN   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_KILL    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_OUTCOME = 2'd2;

   // Evaluator actions
   localparam logic [ACTION_W-1:0] ACT_NONE  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_CALL  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_FORK  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_EXIT  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_WAIT  = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_SLEEP = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_EXTC  = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_FAIL  = 3'd7;

   // Response status
   localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_REJECT      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_EXITED      = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNSUPPORTED = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_INVALID     = 3'd4;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_MOVE,
      ST_FIX,
      ST_CUR_RD,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [REF_W-1:0]    local_ref;
      logic [PID_W-1:0]    target_pid;
      logic [ACTION_W-1:0] action;
      logic                result_is_ref;
      logic [REF_W-1:0]    result_ref;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic                  new_pid_valid;
      logic [PID_W-1:0]      new_pid;
      logic [AFFECTED_W-1:0] affected_index;
      logic [PID_W-1:0]      next_pid_at_cursor;
      logic [REF_W-1:0]      next_local_at_cursor;
      logic [LIVE_W-1:0]     live_count;
      logic                  round_done;
   } rsp_payload_type;

endpackage

`default_nettype wire

FILE: sv/ptrr_if.sv
// Channel interfaces for the process table block: request, response and
// register write channels with valid/ready handshakes.
// Depends on ptrr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ptrr_req_if import ptrr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [REF_W-1:0]    local_ref;
   logic [PID_W-1:0]    target_pid;
   logic [ACTION_W-1:0] action;
   logic                result_is_ref;
   logic [REF_W-1:0]    result_ref;

   modport source (output valid, mode, local_ref, target_pid, action, result_is_ref,
                   result_ref, input ready);
   modport sink (input valid, mode, local_ref, target_pid, action, result_is_ref,
                 result_ref, output ready);
endinterface

interface ptrr_rsp_if import ptrr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic                  new_pid_valid;
   logic [PID_W-1:0]      new_pid;
   logic [AFFECTED_W-1:0] affected_index;
   logic [PID_W-1:0]      next_pid_at_cursor;
   logic [REF_W-1:0]      next_local_at_cursor;
   logic [LIVE_W-1:0]     live_count;
   logic                  round_done;

   modport source (output valid, status, new_pid_valid, new_pid, affected_index,
                   next_pid_at_cursor, next_local_at_cursor, live_count, round_done,
                   input ready);
   modport sink (input valid, status, new_pid_valid, new_pid, affected_index,
                 next_pid_at_cursor, next_local_at_cursor, live_count, round_done,
                 output ready);
endinterface

interface ptrr_csr_if import ptrr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [REF_W-1:0] wdata;

   modport source (output valid, wdata, input ready);
   modport sink (input valid, wdata, output ready);
endinterface

`default_nettype wire

FILE: sv/ptrr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ptrr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/ptrr_ctrl.sv
// Sequencer of the process table: decodes a request, scans and rewrites the
// pid and frame memories, moves the round-robin cursor and builds the response.
// Depends on ptrr_pkg; drives the two ptrr_ram instances in the top level.
`timescale 1ns / 1ps
`default_nettype none

module ptrr_ctrl import ptrr_pkg::*; #(
   parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [REF_W-1:0]               null_ref,
   input  wire logic                           req_valid,
   input  wire req_payload_type                req_payload,
   output logic                                req_ready,
   input  wire logic                           rsp_free,
   output logic                                rsp_load,
   output rsp_payload_type                     rsp_payload,
   output logic [$clog2(TABLE_DEPTH)-1:0]      mem_rd_addr,
   output logic [$clog2(TABLE_DEPTH)-1:0]      mem_wr_addr,
   output logic                                pid_we,
   output logic                                frame_we,
   output logic [PID_W-1:0]                    pid_wdata,
   output logic [REF_W-1:0]                    frame_wdata,
   input  wire logic [PID_W-1:0]               pid_rdata,
   input  wire logic [REF_W-1:0]               frame_rdata
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] ONE_IDX    = IDX_W'(1);
   localparam logic [IDX_W-1:0] FULL_LIMIT = IDX_W'(TABLE_DEPTH - 1);

   state_type            state_ff, state_in;
   req_payload_type      req_ff, req_in;
   logic [IDX_W-1:0]     count_ff, count_in;
   logic [PID_W-1:0]     pid_ctr_ff, pid_ctr_in;
   logic [IDX_W-1:0]     cursor_ff, cursor_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic                 new_valid_ff, new_valid_in;
   logic [PID_W-1:0]     new_pid_ff, new_pid_in;
   logic [IDX_W-1:0]     affected_ff, affected_in;
   logic                 round_done_ff, round_done_in;
   logic                 outcome_ff, outcome_in;
   logic [IDX_W-1:0]     scan_ff, scan_in;
   logic [IDX_W-1:0]     chk_ff, chk_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]     rm_slot_ff, rm_slot_in;

   logic                 full;
   logic                 spawn_ok;
   logic                 valid_ref;
   logic                 fork_ok;
   logic [IDX_W-1:0]     idx;
   logic [STATUS_W-1:0]  kill_code;
   logic                 pid_hit;
   logic                 scan_more;

   // Decode of the held request
   always_comb begin
      full      = (count_ff >= FULL_LIMIT);
      spawn_ok  = (req_ff.local_ref != null_ref) && !full;
      valid_ref = req_ff.result_is_ref && (req_ff.result_ref != null_ref);
      fork_ok   = valid_ref && !full;
      idx       = (cursor_ff < count_ff) ? cursor_ff : '0;
      pid_hit   = chk_valid_ff && (pid_rdata == req_ff.target_pid);
      scan_more = (scan_ff < count_ff);
      case (req_ff.action)
         ACT_NONE:  kill_code = STATUS_OK;
         ACT_CALL:  kill_code = valid_ref ? STATUS_OK : STATUS_UNSUPPORTED;
         ACT_FORK:  kill_code = valid_ref ? STATUS_OK : STATUS_UNSUPPORTED;
         ACT_EXIT:  kill_code = STATUS_EXITED;
         ACT_WAIT:  kill_code = STATUS_UNSUPPORTED;
         ACT_SLEEP: kill_code = STATUS_UNSUPPORTED;
         ACT_EXTC:  kill_code = STATUS_UNSUPPORTED;
         ACT_FAIL:  kill_code = STATUS_INVALID;
         default:   kill_code = STATUS_INVALID;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (req_ff.mode)
               MODE_KILL: state_in = ST_SCAN;
               MODE_OUTCOME: begin
                  if (count_ff != '0 && kill_code != STATUS_OK) begin
                     state_in = ST_MOVE;
                  end else begin
                     state_in = ST_FIX;
                  end
               end
               default: state_in = ST_FIX;
            endcase
         end
         ST_SCAN: begin
            if (pid_hit) begin
               state_in = ST_MOVE;
            end else if (!scan_more && !chk_valid_ff) begin
               state_in = ST_FIX;
            end
         end
         ST_MOVE:   state_in = ST_FIX;
         ST_FIX:    state_in = ST_CUR_RD;
         ST_CUR_RD: state_in = ST_LOAD;
         ST_LOAD: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory controls and handshake outputs
   always_comb begin
      req_in        = req_ff;
      count_in      = count_ff;
      pid_ctr_in    = pid_ctr_ff;
      cursor_in     = cursor_ff;
      pos_in        = pos_ff;
      status_in     = status_ff;
      new_valid_in  = new_valid_ff;
      new_pid_in    = new_pid_ff;
      affected_in   = affected_ff;
      round_done_in = round_done_ff;
      outcome_in    = outcome_ff;
      scan_in       = scan_ff;
      chk_in        = chk_ff;
      chk_valid_in  = chk_valid_ff;
      rm_slot_in    = rm_slot_ff;
      mem_rd_addr   = cursor_ff;
      mem_wr_addr   = count_ff;
      pid_we        = 1'b0;
      frame_we      = 1'b0;
      pid_wdata     = pid_ctr_ff;
      frame_wdata   = req_ff.local_ref;
      req_ready     = (state_ff == ST_IDLE);
      rsp_load      = 1'b0;

      case (state_ff)
         // Take the request and clear the per-request results
         ST_IDLE: begin
            if (req_valid) begin
               req_in        = req_payload;
               status_in     = STATUS_REJECT;
               new_valid_in  = 1'b0;
               new_pid_in    = '0;
               affected_in   = '0;
               round_done_in = 1'b0;
               outcome_in    = 1'b0;
            end
         end

         ST_EXEC: begin
            pos_in = cursor_ff;
            case (req_ff.mode)
               // Append at the end of the table
               MODE_SPAWN: begin
                  if (spawn_ok) begin
                     pid_we       = 1'b1;
                     frame_we     = 1'b1;
                     count_in     = count_ff + ONE_IDX;
                     pid_ctr_in   = pid_ctr_ff + PID_W'(1);
                     status_in    = STATUS_OK;
                     new_valid_in = 1'b1;
                     new_pid_in   = pid_ctr_ff;
                     affected_in  = count_ff;
                  end
               end
               // Start the linear search
               MODE_KILL: begin
                  scan_in      = '0;
                  chk_valid_in = 1'b0;
               end
               // Apply the evaluator's outcome to the cursor process
               MODE_OUTCOME: begin
                  if (count_ff != '0) begin
                     outcome_in  = 1'b1;
                     affected_in = idx;
                     status_in   = STATUS_OK;
                     if (kill_code != STATUS_OK) begin
                        status_in   = kill_code;
                        pos_in      = idx;
                        rm_slot_in  = idx;
                        mem_rd_addr = count_ff - ONE_IDX;
                     end else begin
                        pos_in = idx + ONE_IDX;
                        if (req_ff.action == ACT_CALL) begin
                           mem_wr_addr = idx;
                           frame_wdata = req_ff.result_ref;
                           frame_we    = 1'b1;
                        end else if (req_ff.action == ACT_FORK && fork_ok) begin
                           frame_wdata  = req_ff.result_ref;
                           pid_we       = 1'b1;
                           frame_we     = 1'b1;
                           count_in     = count_ff + ONE_IDX;
                           pid_ctr_in   = pid_ctr_ff + PID_W'(1);
                           new_valid_in = 1'b1;
                           new_pid_in   = pid_ctr_ff;
                        end
                     end
                  end
               end
               default: begin
                  status_in = STATUS_REJECT;
               end
            endcase
         end

         // Compare the entry read last cycle, issue the next read
         ST_SCAN: begin
            if (pid_hit) begin
               rm_slot_in   = chk_ff;
               affected_in  = chk_ff;
               status_in    = STATUS_OK;
               chk_valid_in = 1'b0;
               mem_rd_addr  = count_ff - ONE_IDX;
            end else if (scan_more) begin
               mem_rd_addr  = scan_ff;
               chk_in       = scan_ff;
               chk_valid_in = 1'b1;
               scan_in      = scan_ff + ONE_IDX;
            end else begin
               chk_valid_in = 1'b0;
            end
         end

         // Move the last entry into the freed slot
         ST_MOVE: begin
            mem_wr_addr = rm_slot_ff;
            pid_wdata   = pid_rdata;
            frame_wdata = frame_rdata;
            pid_we      = 1'b1;
            frame_we    = 1'b1;
            count_in    = count_ff - ONE_IDX;
         end

         // Advance the cursor, wrapping it at the end of a round
         ST_FIX: begin
            if (pos_ff >= count_ff) begin
               round_done_in = outcome_ff || (pos_ff != '0);
               cursor_in     = '0;
            end else begin
               cursor_in = pos_ff;
            end
         end

         ST_LOAD: begin
            rsp_load = rsp_free;
         end

         default: begin
         end
      endcase
   end

   // Response built from held results and the cursor entry
   always_comb begin
      rsp_payload.status               = status_ff;
      rsp_payload.new_pid_valid        = new_valid_ff;
      rsp_payload.new_pid              = new_pid_ff;
      rsp_payload.affected_index       = AFFECTED_W'(affected_ff);
      rsp_payload.next_pid_at_cursor   = (count_ff != '0) ? pid_rdata : '0;
      rsp_payload.next_local_at_cursor = (count_ff != '0) ? frame_rdata : '0;
      rsp_payload.live_count           = LIVE_W'(count_ff);
      rsp_payload.round_done           = round_done_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pid_ctr_ff   <= '0;
         cursor_ff    <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pid_ctr_ff   <= pid_ctr_in;
         cursor_ff    <= cursor_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   // Request and result holding registers
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      pos_ff        <= pos_in;
      status_ff     <= status_in;
      new_valid_ff  <= new_valid_in;
      new_pid_ff    <= new_pid_in;
      affected_ff   <= affected_in;
      round_done_ff <= round_done_in;
      outcome_ff    <= outcome_in;
      scan_ff       <= scan_in;
      chk_ff        <= chk_in;
      rm_slot_ff    <= rm_slot_in;
   end

`ifndef SYNTHESIS
   a_cursor_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (cursor_ff < count_ff || cursor_ff == '0))
      else $error("cursor left outside the live table");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      (pid_we || frame_we) |-> (state_ff == ST_EXEC || state_ff == ST_MOVE))
      else $error("table written outside execute or move");

   a_count_changes: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(count_ff))
         |-> ($past(state_ff) == ST_EXEC || $past(state_ff) == ST_MOVE))
      else $error("process count changed outside execute or move");

   a_pid_steps: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(pid_ctr_ff))
         |-> (pid_ctr_ff == $past(pid_ctr_ff) + PID_W'(1)))
      else $error("pid counter moved by other than one");
`endif

endmodule

`default_nettype wire

FILE: sv/process_table_round_robin.sv
// Top level of the process table: register write port, pid and frame memories,
// sequencer and response output register.
// Depends on ptrr_pkg, ptrr_if, ptrr_ram and ptrr_ctrl.
`timescale 1ns / 1ps
`default_nettype none

// Process table with round-robin cursor. Requests spawn a process, kill one by
// pid, or apply an evaluator outcome to the process at the cursor; each request
// gives exactly one response. Pids and frame references live in two RAMs with a
// registered read, and there is no clearing pass after reset. One request is
// worked on at a time: spawn, outcome and unused mode pass through execute,
// cursor fix, cursor read and response load, and an outcome that removes the
// process adds a move step before the cursor fix. Kill by pid reads one table
// entry per cycle through the RAM read port until the pid is found or the live
// entries run out. A waiting response sits in its own output register, so the
// next request is taken while it waits. The null reference register should be
// written only while no request is in flight.
module process_table_round_robin import ptrr_pkg::*; #(
   parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   ptrr_req_if.sink   req_ch,
   ptrr_rsp_if.source rsp_ch,
   ptrr_csr_if.sink   csr_ch
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic [REF_W-1:0] null_ref_ff, null_ref_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_ff, rsp_in;

   req_payload_type  req_payload;
   rsp_payload_type  rsp_payload;
   logic             rsp_free;
   logic             rsp_load;
   logic [IDX_W-1:0] mem_rd_addr;
   logic [IDX_W-1:0] mem_wr_addr;
   logic             pid_we;
   logic             frame_we;
   logic [PID_W-1:0] pid_wdata;
   logic [REF_W-1:0] frame_wdata;
   logic [PID_W-1:0] pid_rdata;
   logic [REF_W-1:0] frame_rdata;

   // Null reference register, always ready
   assign csr_ch.ready = 1'b1;
   assign null_ref_in  = csr_ch.valid ? csr_ch.wdata : null_ref_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         null_ref_ff <= '0;
      end else begin
         null_ref_ff <= null_ref_in;
      end
   end

   // Gather the request payload
   always_comb begin
      req_payload.mode          = req_ch.mode;
      req_payload.local_ref     = req_ch.local_ref;
      req_payload.target_pid    = req_ch.target_pid;
      req_payload.action        = req_ch.action;
      req_payload.result_is_ref = req_ch.result_is_ref;
      req_payload.result_ref    = req_ch.result_ref;
   end

   ptrr_ram #(
      .WIDTH (PID_W),
      .DEPTH (TABLE_DEPTH)
   ) u_pid_ram (
      .clock   (clock),
      .wr_en   (pid_we),
      .wr_addr (mem_wr_addr),
      .wr_data (pid_wdata),
      .rd_addr (mem_rd_addr),
      .rd_data (pid_rdata)
   );

   ptrr_ram #(
      .WIDTH (REF_W),
      .DEPTH (TABLE_DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (frame_we),
      .wr_addr (mem_wr_addr),
      .wr_data (frame_wdata),
      .rd_addr (mem_rd_addr),
      .rd_data (frame_rdata)
   );

   ptrr_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .null_ref    (null_ref_ff),
      .req_valid   (req_ch.valid),
      .req_payload (req_payload),
      .req_ready   (req_ch.ready),
      .rsp_free    (rsp_free),
      .rsp_load    (rsp_load),
      .rsp_payload (rsp_payload),
      .mem_rd_addr (mem_rd_addr),
      .mem_wr_addr (mem_wr_addr),
      .pid_we      (pid_we),
      .frame_we    (frame_we),
      .pid_wdata   (pid_wdata),
      .frame_wdata (frame_wdata),
      .pid_rdata   (pid_rdata),
      .frame_rdata (frame_rdata)
   );

   // Response output register
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_in       = rsp_payload;
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid                = rsp_valid_ff;
   assign rsp_ch.status               = rsp_ff.status;
   assign rsp_ch.new_pid_valid        = rsp_ff.new_pid_valid;
   assign rsp_ch.new_pid              = rsp_ff.new_pid;
   assign rsp_ch.affected_index       = rsp_ff.affected_index;
   assign rsp_ch.next_pid_at_cursor   = rsp_ff.next_pid_at_cursor;
   assign rsp_ch.next_local_at_cursor = rsp_ff.next_local_at_cursor;
   assign rsp_ch.live_count           = rsp_ff.live_count;
   assign rsp_ch.round_done           = rsp_ff.round_done;

`ifndef SYNTHESIS
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ch.ready))
      else $error("response loaded over one still waiting");

   a_one_rsp_per_req: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid_ff && rsp_ch.live_count == $past(rsp_payload.live_count)))
      else $error("loaded response not presented");

   a_ready_not_while_loading: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !req_ch.ready)
      else $error("request taken while a response is being loaded");
`endif

endmodule

`default_nettype wire
